// File: hdl/rbp_pkg.sv
package rbp_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       operation;
      logic [7:0] new_byte;
      logic [1:0] size_log2;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        generator_on;
   } rsp_type;

   typedef enum logic {
      OP_FILL = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic {
      KIND_FILL,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] fill_byte;
      logic [2:0] size_m1;
   } cmd_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_FETCH,
      B_LAST
   } back_state_type;

endpackage

// File: hdl/rbp_front.sv
module rbp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rbp_pkg::req_type req_item,
   input  logic             q_full,
   output logic             push,
   output rbp_pkg::cmd_type push_cmd
);

   logic             valid_ff;
   logic             valid_in;
   rbp_pkg::cmd_type cmd_ff;
   rbp_pkg::cmd_type cmd_in;
   logic             accept;

   assign busy     = valid_ff && q_full;
   assign accept   = start && !busy;
   assign push     = valid_ff;
   assign push_cmd = cmd_ff;

   always_comb begin
      cmd_in           = cmd_ff;
      cmd_in.fill_byte = req_item.new_byte;
      unique case (rbp_pkg::op_type'(req_item.operation))
         rbp_pkg::OP_FILL: cmd_in.kind = rbp_pkg::KIND_FILL;
         rbp_pkg::OP_READ: cmd_in.kind = rbp_pkg::KIND_READ;
         default:          cmd_in.kind = rbp_pkg::KIND_FILL;
      endcase
      unique case (req_item.size_log2)
         2'd0:    cmd_in.size_m1 = 3'd0;
         2'd1:    cmd_in.size_m1 = 3'd1;
         2'd2:    cmd_in.size_m1 = 3'd3;
         2'd3:    cmd_in.size_m1 = 3'd7;
         default: cmd_in.size_m1 = 3'd0;
      endcase
      if (accept) begin
         valid_in = 1'b1;
      end else if (valid_ff && !q_full) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// File: hdl/rbp_queue.sv
module rbp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbp_pkg::cmd_type push_cmd,
   output logic             q_full,
   input  logic             pop,
   output logic             q_valid,
   output rbp_pkg::cmd_type q_cmd
);

   localparam int PTR_W = (rbp_pkg::QUEUE_DEPTH > 1) ? $clog2(rbp_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(rbp_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rbp_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rbp_pkg::QUEUE_DEPTH - 1);

   rbp_pkg::cmd_type entry_ff [rbp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign q_full  = (count_ff == FULL_CNT);
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hdl/rbp_back.sv
module rbp_back #(
   parameter int DEPTH = rbp_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  rbp_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_strobe,
   output rbp_pkg::rsp_type rsp_item
);

   localparam int SLOT_W = $clog2(DEPTH);
   localparam logic [SLOT_W:0]   DEPTH_S = (SLOT_W + 1)'(DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
   localparam logic [31:0]       DEPTH_C = 32'(DEPTH);
   localparam longint unsigned   WRAP_REM_L = (64'd1 << 32) % DEPTH;
   localparam logic [SLOT_W-1:0] WRAP_REM = SLOT_W'(WRAP_REM_L);

   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                  input logic [SLOT_W-1:0] d);
      logic [SLOT_W:0] sum;
      sum = {1'b0, s} + {1'b0, d};
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_next(input logic [31:0] count,
                                                   input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] res;
      if (count == '1 || s == LAST_SLOT) begin
         res = '0;
      end else begin
         res = s + 1'b1;
      end
      return res;
   endfunction

   rbp_pkg::back_state_type state_ff;
   rbp_pkg::back_state_type state_in;

   logic [7:0]        pool_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;

   logic [31:0]       read_count_ff;
   logic [31:0]       read_count_in;
   logic [SLOT_W-1:0] read_slot_ff;
   logic [SLOT_W-1:0] read_slot_in;
   logic [31:0]       write_count_ff;
   logic [31:0]       write_count_in;
   logic [SLOT_W-1:0] write_slot_ff;
   logic [SLOT_W-1:0] write_slot_in;
   logic              running_ff;
   logic              running_in;

   logic [31:0]       cur_count_ff;
   logic [31:0]       cur_count_in;
   logic [SLOT_W-1:0] cur_slot_ff;
   logic [SLOT_W-1:0] cur_slot_in;
   logic [2:0]        issue_left_ff;
   logic [2:0]        issue_left_in;
   logic [2:0]        byte_idx_ff;
   logic [2:0]        byte_idx_in;
   logic [63:0]       acc_ff;
   logic [63:0]       acc_in;
   logic [63:0]       acc_cap;
   logic              rd_pend_ff;
   logic              rd_pend_in;
   logic [7:0]        rd_byte_ff;
   logic              rd_vld_ff;

   logic              rsp_strobe_ff;
   logic              rsp_strobe_in;
   rbp_pkg::rsp_type  rsp_item_ff;
   rbp_pkg::rsp_type  rsp_item_in;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_slot;

   logic [31:0]       diff;
   logic [31:0]       diff_m1;
   logic [32:0]       r_less;
   logic              pull;
   logic              stop;
   logic [31:0]       fill_count;
   logic [SLOT_W-1:0] fill_slot;
   logic [32:0]       align_sum;
   logic [31:0]       align_idx;
   logic [2:0]        align_delta;
   logic [SLOT_W-1:0] align_slot;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   always_comb begin
      diff       = read_count_ff - write_count_ff;
      diff_m1    = read_count_ff + ~write_count_ff;
      r_less     = {1'b0, read_count_ff} - {1'b0, DEPTH_C};
      pull       = !diff[31] && (diff > DEPTH_C);
      stop       = !pull && ((diff_m1 == '0) || diff_m1[31]);
      fill_count = pull ? r_less[31:0] : write_count_ff;
      if (!pull) begin
         fill_slot = write_slot_ff;
      end else if (r_less[32]) begin
         fill_slot = slot_add(read_slot_ff, WRAP_REM);
      end else begin
         fill_slot = read_slot_ff;
      end

      align_sum   = {1'b0, read_count_ff} + {30'd0, cmd.size_m1};
      align_idx   = align_sum[31:0] & ~{29'd0, cmd.size_m1};
      align_delta = align_idx[2:0] - read_count_ff[2:0];
      align_slot  = align_sum[32] ? '0 : slot_add(read_slot_ff, SLOT_W'(align_delta));

      acc_cap = acc_ff;
      if (rd_pend_ff) begin
         acc_cap[{byte_idx_ff, 3'b000} +: 8] = rd_vld_ff ? rd_byte_ff : 8'h00;
      end
   end

   always_comb begin
      state_in       = state_ff;
      read_count_in  = read_count_ff;
      read_slot_in   = read_slot_ff;
      write_count_in = write_count_ff;
      write_slot_in  = write_slot_ff;
      running_in     = running_ff;
      cur_count_in   = cur_count_ff;
      cur_slot_in    = cur_slot_ff;
      issue_left_in  = issue_left_ff;
      byte_idx_in    = byte_idx_ff + {2'b00, rd_pend_ff};
      acc_in         = acc_cap;
      rd_pend_in     = 1'b0;
      rsp_strobe_in  = 1'b0;
      rsp_item_in    = rsp_item_ff;
      cmd_pop        = 1'b0;
      wr_en          = 1'b0;
      wr_slot        = fill_slot;
      unique case (state_ff)
         rbp_pkg::B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  rbp_pkg::KIND_FILL: begin
                     wr_en                    = 1'b1;
                     write_count_in           = fill_count + 32'd1;
                     write_slot_in            = slot_next(fill_count, fill_slot);
                     running_in               = running_ff && !stop;
                     rsp_strobe_in            = 1'b1;
                     rsp_item_in.read_data    = '0;
                     rsp_item_in.generator_on = running_ff && !stop;
                  end
                  rbp_pkg::KIND_READ: begin
                     cur_count_in  = align_idx;
                     cur_slot_in   = align_slot;
                     issue_left_in = cmd.size_m1;
                     byte_idx_in   = '0;
                     acc_in        = '0;
                     state_in      = rbp_pkg::B_FETCH;
                  end
                  default: begin
                     state_in = rbp_pkg::B_IDLE;
                  end
               endcase
            end
         end
         rbp_pkg::B_FETCH: begin
            rd_pend_in   = 1'b1;
            cur_count_in = cur_count_ff + 32'd1;
            cur_slot_in  = slot_next(cur_count_ff, cur_slot_ff);
            if (issue_left_ff == '0) begin
               state_in = rbp_pkg::B_LAST;
            end else begin
               issue_left_in = issue_left_ff - 3'd1;
            end
         end
         rbp_pkg::B_LAST: begin
            rsp_strobe_in            = 1'b1;
            rsp_item_in.read_data    = acc_cap;
            rsp_item_in.generator_on = 1'b1;
            read_count_in            = cur_count_ff;
            read_slot_in             = cur_slot_ff;
            running_in               = 1'b1;
            state_in                 = rbp_pkg::B_IDLE;
         end
         default: begin
            state_in = rbp_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rbp_pkg::B_IDLE;
         read_count_ff  <= DEPTH_C;
         read_slot_ff   <= '0;
         write_count_ff <= '0;
         write_slot_ff  <= '0;
         running_ff     <= 1'b1;
         rd_pend_ff     <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         valid_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         read_count_ff  <= read_count_in;
         read_slot_ff   <= read_slot_in;
         write_count_ff <= write_count_in;
         write_slot_ff  <= write_slot_in;
         running_ff     <= running_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         if (wr_en) begin
            valid_ff[wr_slot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_count_ff  <= cur_count_in;
      cur_slot_ff   <= cur_slot_in;
      issue_left_ff <= issue_left_in;
      byte_idx_ff   <= byte_idx_in;
      acc_ff        <= acc_in;
      rsp_item_ff   <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pool_ff[wr_slot] <= cmd.fill_byte;
      end
      rd_byte_ff <= pool_ff[cur_slot_ff];
      rd_vld_ff  <= valid_ff[cur_slot_ff];
   end

endmodule

// File: hdl/random_byte_pool_ring.sv
// channel   ports                           handshake
// input     start, busy, req_item           taken when start is high and busy is low
// result    rsp_strobe, rsp_item            one cycle per result, no back-pressure
//
// A transaction passes a classify register and a two-entry queue before the sequencer.
// The sequencer handles a byte arrival in its idle state, and a read of 2**size_log2 bytes in its
// idle, fetch and last states, one pool byte per cycle through the byte memory.
// busy rises when the classify register and the queue are both full.
// Pool valid bits make unwritten bytes read as zero.
module random_byte_pool_ring #(
   parameter int DEPTH = rbp_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rbp_pkg::req_type req_item,
   output logic             rsp_strobe,
   output rbp_pkg::rsp_type rsp_item
);

   logic             q_full;
   logic             push;
   rbp_pkg::cmd_type push_cmd;
   logic             pop;
   logic             q_valid;
   rbp_pkg::cmd_type q_cmd;

   rbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   rbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .q_full   (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   rbp_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (q_cmd),
      .cmd_pop    (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// File: verif/random_byte_pool_ring_tb.sv
`timescale 1ns / 100ps

module random_byte_pool_ring_tb;

   localparam logic [31:0] POOL_DEPTH = rbp_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1450;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 30;

   class byte_pool_tracker;
      logic [7:0]       pool_mem [POOL_DEPTH];
      logic [31:0]      rd_cnt;
      logic [31:0]      wr_cnt;
      logic             gen_running;
      rbp_pkg::rsp_type owed_rsp [$];
      int               mismatch_cnt;
      int               fill_cnt;
      int               read_cnt;
      int               stop_cnt;
      int               checked_cnt;

      function new();
         foreach (pool_mem[i]) pool_mem[i] = 8'h00;
         rd_cnt = POOL_DEPTH;
         wr_cnt = 32'd0;
         gen_running = 1'b1;
         mismatch_cnt = 0;
         fill_cnt = 0;
         read_cnt = 0;
         stop_cnt = 0;
         checked_cnt = 0;
      endfunction

      function void note_request(rbp_pkg::req_type item);
         rbp_pkg::rsp_type exp_rsp;
         logic [31:0]      lag;
         logic [31:0]      span;
         logic [31:0]      aligned;
         exp_rsp = '0;
         if (rbp_pkg::op_type'(item.operation) == rbp_pkg::OP_FILL) begin
            lag = rd_cnt - wr_cnt;
            if (lag > POOL_DEPTH && !lag[31]) begin
               wr_cnt = rd_cnt - POOL_DEPTH;
            end
            pool_mem[wr_cnt % POOL_DEPTH] = item.new_byte;
            wr_cnt = wr_cnt + 32'd1;
            lag = rd_cnt - wr_cnt;
            if (lag == 32'd0 || lag[31]) begin
               if (gen_running) stop_cnt++;
               gen_running = 1'b0;
            end
            fill_cnt++;
         end else begin
            span = 32'd1 << item.size_log2;
            aligned = (rd_cnt + span - 32'd1) & ~(span - 32'd1);
            for (int k = 0; k < span; k++) begin
               exp_rsp.read_data[8*k +: 8] = pool_mem[(aligned + 32'(k)) % POOL_DEPTH];
            end
            rd_cnt = aligned + span;
            gen_running = 1'b1;
            read_cnt++;
         end
         exp_rsp.generator_on = gen_running;
         owed_rsp.push_back(exp_rsp);
      endfunction

      function void check_response(rbp_pkg::rsp_type got);
         rbp_pkg::rsp_type want;
         if (owed_rsp.size() == 0) begin
            $display("%0t: response with none expected: read_data %h generator_on %b",
                     $time, got.read_data, got.generator_on);
            mismatch_cnt++;
            return;
         end
         want = owed_rsp.pop_front();
         checked_cnt++;
         if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h",
                     $time, want.read_data, got.read_data);
            mismatch_cnt++;
         end
         if (got.generator_on !== want.generator_on) begin
            $display("%0t: generator_on expected %b actual %b",
                     $time, want.generator_on, got.generator_on);
            mismatch_cnt++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   rbp_pkg::req_type req_item;
   logic             rsp_strobe;
   rbp_pkg::rsp_type rsp_item;
   int               idle_cycles;

   byte_pool_tracker tracker = new();

   random_byte_pool_ring DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) tracker.note_request(req_item);
         if (rsp_strobe) tracker.check_response(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic rbp_pkg::req_type make_req(rbp_pkg::op_type op, logic [7:0] data,
                                                 logic [1:0] lg);
      rbp_pkg::req_type item;
      item.operation = op;
      item.new_byte = data;
      item.size_log2 = lg;
      return item;
   endfunction

   task automatic send_item(input rbp_pkg::req_type item);
      start <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      int               burst_left;
      int               phase_left;
      int               read_pct;
      int               gap;
      rbp_pkg::req_type item;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // stale reads of every size, leaving the writer far behind
      for (int lg = 0; lg < 4; lg++) begin
         send_item(make_req(rbp_pkg::OP_READ, 8'hFF, 2'(lg)));
      end
      // pull the writer up, fill until the generator stops, then overrun
      for (int k = 0; k < 17; k++) begin
         if (k == 0) begin
            item = make_req(rbp_pkg::OP_FILL, 8'hFF, 2'd3);
         end else if (k == 1) begin
            item = make_req(rbp_pkg::OP_FILL, 8'h00, 2'd0);
         end else begin
            item = make_req(rbp_pkg::OP_FILL, 8'(k * 37 + 3), 2'(k));
         end
         send_item(item);
      end
      // a one-byte read that misaligns, then reads that force alignment
      send_item(make_req(rbp_pkg::OP_READ, 8'h00, 2'd0));
      send_item(make_req(rbp_pkg::OP_READ, 8'h5A, 2'd1));
      send_item(make_req(rbp_pkg::OP_READ, 8'hA5, 2'd3));

      burst_left = 0;
      phase_left = 0;
      read_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(120, 20);
            read_pct = 10 + 20 * $urandom_range(4);
         end
         if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(8, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         item.operation = ($urandom_range(99) < read_pct) ? rbp_pkg::OP_READ
                                                          : rbp_pkg::OP_FILL;
         item.new_byte = 8'($urandom);
         item.size_log2 = 2'($urandom);
         send_item(item);
         burst_left--;
         phase_left--;
      end
      start <= 1'b0;

      while (tracker.owed_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d byte arrivals and %0d reads of 1 to 8 bytes, %0d generator stops",
               tracker.fill_cnt, tracker.read_cnt, tracker.stop_cnt);
      $display("Checked %0d responses, %0d mismatches",
               tracker.checked_cnt, tracker.mismatch_cnt);
      if (tracker.mismatch_cnt == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/rbp_pkg.sv
hdl/rbp_front.sv
hdl/rbp_queue.sv
hdl/rbp_back.sv
hdl/random_byte_pool_ring.sv
verif/random_byte_pool_ring_tb.sv
